### design/swcm_pkg.sv
// Shared types and constants for the segment window color match unit.
`default_nettype none

package swcm_pkg;

	localparam int COORD_W = 8;
	localparam int COLOR_W = 8;
	localparam int PIXEL_W = 3 * COLOR_W;
	localparam int MASK_W  = 49;
	localparam int COUNT_W = 6;
	localparam int BIT_W   = 6;
	localparam int CFG_W   = 9;
	localparam int CFGI_W  = 2;
	localparam int RAD_W   = 2;

	// Request operation codes
	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFGI_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_RADIUS = 2'd2
	} cfg_reg_t;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CENTER = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	typedef struct packed {
		logic [0:0]         op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} req_t;

	typedef struct packed {
		logic [MASK_W-1:0]  match_mask;
		logic [COUNT_W-1:0] match_count;
	} rsp_t;

	// Frame memory control from the sequencer
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

`default_nettype wire

### design/swcm_frame_mem.sv
// Single-port frame memory with registered read.
`default_nettype none

module swcm_frame_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  wire                          clk,
	input  wire swcm_pkg::mem_ctl_t      ctl,
	input  wire [AW-1:0]                 addr,
	input  wire [swcm_pkg::PIXEL_W-1:0]  wdata,
	output logic [swcm_pkg::PIXEL_W-1:0] rdata
);
	import swcm_pkg::*;

	logic [PIXEL_W-1:0] mem [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### design/segment_window_color_match_unit.sv
// Top level: frame store with windowed same-color neighbor mask queries.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_data  (op, col, row, red, green, blue)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data  (match_mask, match_count)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A query steps through center read, one frame memory read per in-image
// window position through the single memory port, drain and result load;
// a query outside the image goes straight to the result load.
// Reset clears the sequencer, result valid and configuration registers;
// the frame memory is not cleared. While an earlier result is still
// stalled, a finished query waits before its load and req_stall stays high.
`default_nettype none

module segment_window_color_match_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 3
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        req_valid,
	output logic                       req_stall,
	input  wire swcm_pkg::req_t        req_data,
	output logic                       rsp_valid,
	input  wire                        rsp_stall,
	output swcm_pkg::rsp_t             rsp_data,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [swcm_pkg::CFGI_W-1:0] cfg_index,
	input  wire [swcm_pkg::CFG_W-1:0]  cfg_data
);
	import swcm_pkg::*;

	localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int HW        = $clog2(MAX_HEIGHT + 1);
	localparam int WIDTH_RST  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int HEIGHT_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

	logic [WW-1:0]    width_q;
	logic [HW-1:0]    height_q;
	logic [RAD_W-1:0] radius_q;

	state_t             state_q;
	logic [COORD_W-1:0] col_q, row_q;
	logic signed [2:0]  r_q, dx_q, dy_q;
	logic [BIT_W-1:0]   bit_q;
	logic [PIXEL_W-1:0] center_q;
	logic [MASK_W-1:0]  mask_q;
	logic [COUNT_W-1:0] count_q;
	logic               pend_s1;
	logic [BIT_W-1:0]   bit_s1;

	logic               req_xfer, req_inside;
	logic signed [9:0]  wx, wy;
	logic               win_inside, win_last;
	logic [31:0]        addr_wide;
	logic [AW-1:0]      mem_addr;
	mem_ctl_t           mem_ctl;
	logic [PIXEL_W-1:0] mem_rdata;
	logic [2:0]         r_next;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;

	// Configuration registers, clamped to their legal range on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WIDTH_RST);
			height_q <= HW'(HEIGHT_RST);
			radius_q <= RAD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIDTH: begin
					if (cfg_data == '0) width_q <= WW'(1);
					else if (32'(cfg_data) > 32'(MAX_WIDTH)) width_q <= WW'(MAX_WIDTH);
					else width_q <= WW'(cfg_data);
				end
				CFG_HEIGHT: begin
					if (cfg_data == '0) height_q <= HW'(1);
					else if (32'(cfg_data) > 32'(MAX_HEIGHT)) height_q <= HW'(MAX_HEIGHT);
					else height_q <= HW'(cfg_data);
				end
				CFG_RADIUS: begin
					if (32'(cfg_data[RAD_W-1:0]) > 32'(MAX_RADIUS))
						radius_q <= RAD_W'(MAX_RADIUS);
					else
						radius_q <= cfg_data[RAD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign req_inside = (32'(req_data.col) < 32'(width_q)) &&
	                    (32'(req_data.row) < 32'(height_q));

	// Window position under scan
	assign wx = $signed({2'b00, col_q}) + $signed({{7{dx_q[2]}}, dx_q});
	assign wy = $signed({2'b00, row_q}) + $signed({{7{dy_q[2]}}, dy_q});
	assign win_inside = !wx[9] && !wy[9] &&
	                    (32'(wx[8:0]) < 32'(width_q)) && (32'(wy[8:0]) < 32'(height_q));
	assign win_last = (dx_q == r_q) && (dy_q == r_q);
	assign r_next   = {1'b0, radius_q};

	// Memory address and control
	always_comb begin
		mem_ctl = '0;
		if (state_q == S_IDLE) begin
			addr_wide = 32'(req_data.row) * 32'(MAX_WIDTH) + 32'(req_data.col);
			mem_ctl.we = req_xfer && (req_data.op == OP_WRITE) && req_inside;
			mem_ctl.re = req_xfer && (req_data.op == OP_QUERY) && req_inside;
		end else begin
			addr_wide = 32'(wy[8:0]) * 32'(MAX_WIDTH) + 32'(wx[8:0]);
			mem_ctl.re = (state_q == S_SCAN) && win_inside;
		end
	end
	assign mem_addr = addr_wide[AW-1:0];

	swcm_frame_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.ctl  (mem_ctl),
		.addr (mem_addr),
		.wdata({req_data.blue, req_data.green, req_data.red}),
		.rdata(mem_rdata)
	);

	// Query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_s1   <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			// one compare pending per in-image window read
			pend_s1 <= (state_q == S_SCAN) && win_inside;
			// result valid: set on load, cleared on transfer
			if (state_q == S_DONE && (!rsp_valid || !rsp_stall)) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer && (req_data.op == OP_QUERY)) begin
						state_q <= req_inside ? S_CENTER : S_DONE;
					end
				end
				S_CENTER: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (win_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Query datapath: window counters, compare and accumulate
	always_ff @(posedge clk) begin
		bit_s1 <= bit_q;
		if (state_q == S_IDLE && req_xfer) begin
			col_q   <= req_data.col;
			row_q   <= req_data.row;
			r_q     <= r_next;
			dx_q    <= -r_next;
			dy_q    <= -r_next;
			bit_q   <= '0;
			mask_q  <= '0;
			count_q <= '0;
		end
		if (state_q == S_CENTER) begin
			center_q <= mem_rdata;
		end
		if (state_q == S_SCAN) begin
			bit_q <= bit_q + BIT_W'(1);
			if (dx_q == r_q) begin
				dx_q <= -r_q;
				dy_q <= dy_q + 3'sd1;
			end else begin
				dx_q <= dx_q + 3'sd1;
			end
		end
		if (pend_s1 && (mem_rdata == center_q)) begin
			mask_q[bit_s1] <= 1'b1;
			count_q        <= count_q + COUNT_W'(1);
		end
		if (state_q == S_DONE && (!rsp_valid || !rsp_stall)) begin
			rsp_data.match_mask  <= mask_q;
			rsp_data.match_count <= count_q;
		end
	end

endmodule

`default_nettype wire
